@@ hw/rtl/urlpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, character codes and helpers for the URL path decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  // character codes
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  // results that one input byte can cause at most
  localparam int unsigned MAX_RES      = 4;
  localparam int unsigned RES_IDX_BITS = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_BITS = $clog2(MAX_RES + 1);

  localparam int unsigned CONS_BITS = 16;

  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_PCT     = 2'd1,
    PH_HEX     = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b0, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = {1'b0, 4'(b - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/urlpd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlpd_in_if / urlpd_out_if
// Valid/ready channels for raw path bytes and decoded results.
// ----------------------------------------------------------------------------
interface urlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface urlpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_end;
  logic [15:0] consumed;

  modport source (output valid, output out_byte, output is_end, output consumed,
                  input ready);
  modport sink   (input valid, input out_byte, input is_end, input consumed,
                  output ready);
endinterface

@@ hw/rtl/url_path_percent_decoder.sv @@
`timescale 1ns / 1ps
// An input byte passes the input register, then the result buffer, before its
// first result goes out. Throughput: one byte per cycle while each byte yields
// at most one result and the output is ready; a byte that yields more results
// (up to 4) holds the input while the result buffer drains them one by one.
// Reset (rst_n low, synchronous): pipeline empty, decoder back in normal phase
// with zero count and no held digit.
// ----------------------------------------------------------------------------
// url_path_percent_decoder
// Decodes percent escapes and '+' in a URL path, stops the path at '?'
// and reports the consumed byte count in an end result.
// ----------------------------------------------------------------------------
module url_path_percent_decoder #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  urlpd_in_if.sink    in_ch,
  urlpd_out_if.source out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // decoder state
  urlpd_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]            held_r, held_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;

  // result buffer
  logic [7:0]                          ent_r [urlpd_pkg::MAX_RES];
  logic [urlpd_pkg::RES_CNT_BITS-1:0]  bcnt_r;
  logic [urlpd_pkg::RES_IDX_BITS-1:0]  bidx_r;
  logic                                bend_r;
  logic [urlpd_pkg::CONS_BITS-1:0]     bcons_r;

  // decode results for the byte in the input register
  logic [7:0]                          res_byte [urlpd_pkg::MAX_RES];
  logic [urlpd_pkg::RES_CNT_BITS-1:0]  res_n;
  logic                                res_end;

  logic last_out, drain_done, bundle_free, s1_go, out_xfer;

  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign last_out    = (bidx_r == urlpd_pkg::RES_IDX_BITS'(bcnt_r - 1'b1));
  assign drain_done  = out_xfer && last_out;
  assign bundle_free = (bcnt_r == '0) || drain_done;
  assign s1_go       = s1_valid_r && bundle_free;
  assign in_ch.ready = !s1_valid_r || s1_go;

  assign cnt_inc = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    logic       normal;
    logic       query_end;
    logic [4:0] hx;
    logic [4:0] hh;
    logic [urlpd_pkg::RES_CNT_BITS-1:0] n;
    normal    = 1'b1;
    query_end = 1'b0;
    hx        = urlpd_pkg::hex_value(s1_byte_r);
    hh        = urlpd_pkg::hex_value(held_r);
    n         = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    res_end   = 1'b0;
    for (int i = 0; i < urlpd_pkg::MAX_RES; i++) begin
      res_byte[i] = '0;
    end

    if (phase_r == urlpd_pkg::PH_DISCARD) begin
      if (s1_last_r) begin
        phase_nxt = urlpd_pkg::PH_NORMAL;
        held_nxt  = '0;
        cnt_nxt   = '0;
      end
    end else begin
      cnt_nxt = cnt_inc;
      if (phase_r == urlpd_pkg::PH_PCT) begin
        if (!hx[4]) begin
          held_nxt  = s1_byte_r;
          phase_nxt = urlpd_pkg::PH_HEX;
          normal    = 1'b0;
        end else begin
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = urlpd_pkg::CH_PCT;
          n         = n + 1'b1;
          phase_nxt = urlpd_pkg::PH_NORMAL;
        end
      end else if (phase_r == urlpd_pkg::PH_HEX) begin
        phase_nxt = urlpd_pkg::PH_NORMAL;
        if (!hx[4]) begin
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = {hh[3:0], hx[3:0]};
          n      = n + 1'b1;
          normal = 1'b0;
        end else begin
          // broken escape: literal '%' and the held digit
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = urlpd_pkg::CH_PCT;
          n = n + 1'b1;
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = held_r;
          n = n + 1'b1;
        end
        held_nxt = '0;
      end

      if (normal) begin
        if (s1_byte_r == urlpd_pkg::CH_PCT) begin
          phase_nxt = urlpd_pkg::PH_PCT;
        end else if (s1_byte_r == urlpd_pkg::CH_QUERY) begin
          n         = n + 1'b1;
          res_end   = 1'b1;
          query_end = 1'b1;
          if (s1_last_r) begin
            phase_nxt = urlpd_pkg::PH_NORMAL;
            held_nxt  = '0;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = urlpd_pkg::PH_DISCARD;
          end
        end else if (s1_byte_r == urlpd_pkg::CH_PLUS) begin
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = urlpd_pkg::CH_SPACE;
          n = n + 1'b1;
        end else begin
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = s1_byte_r;
          n = n + 1'b1;
        end
      end

      if (s1_last_r && !query_end) begin
        // escape cut by end of string goes out literally
        if (phase_nxt == urlpd_pkg::PH_PCT) begin
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = urlpd_pkg::CH_PCT;
          n = n + 1'b1;
        end else if (phase_nxt == urlpd_pkg::PH_HEX) begin
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = urlpd_pkg::CH_PCT;
          n = n + 1'b1;
          res_byte[n[urlpd_pkg::RES_IDX_BITS-1:0]] = held_nxt;
          n = n + 1'b1;
        end
        n         = n + 1'b1;
        res_end   = 1'b1;
        phase_nxt = urlpd_pkg::PH_NORMAL;
        held_nxt  = '0;
        cnt_nxt   = '0;
      end
    end
    res_n = n;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.in_byte;
      s1_last_r <= in_ch.is_last;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urlpd_pkg::PH_NORMAL;
      held_r  <= '0;
      cnt_r   <= '0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      bidx_r <= '0;
    end else if (s1_go) begin
      bcnt_r <= res_n;
      bidx_r <= '0;
    end else if (out_xfer) begin
      if (last_out) begin
        bcnt_r <= '0;
      end else begin
        bidx_r <= bidx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_n != '0) begin
      for (int i = 0; i < urlpd_pkg::MAX_RES; i++) begin
        ent_r[i] <= res_byte[i];
      end
      bend_r  <= res_end;
      bcons_r <= urlpd_pkg::CONS_BITS'(cnt_inc);
    end
  end

  assign out_ch.valid    = (bcnt_r != '0);
  assign out_ch.is_end   = bend_r && last_out;
  assign out_ch.out_byte = out_ch.is_end ? 8'h00 : ent_r[bidx_r];
  assign out_ch.consumed = out_ch.is_end ? bcons_r : '0;

endmodule
